// ===== sv/spc_pkg.sv =====
package spc_pkg;

	// fixed field widths
	localparam int unsigned ACT_W = 3;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned LOWV_W = 16;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned IDX_W = 7;

	// request codes
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FIND = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [KEY_W-1:0] key;
		logic [LOWV_W-1:0] low_value;
	} spc_request_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic found;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] match_count;
		logic [IDX_W-1:0] pair_count;
		logic [KEY_W-1:0] header_key;
	} spc_result_t;

	// compare flags of one cell against the request
	typedef struct packed {
		logic lt_pair;
		logic lt_key;
		logic le_key;
		logic eq_pair;
	} spc_flags_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
	} spc_cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_RESOLVE,
		S_APPLY,
		S_FINISH
	} spc_state_t;

endpackage

// ===== sv/spc_cell.sv =====
module spc_cell #(
	parameter int unsigned LOW_BITS = 16
) (
	input  logic                      clk,
	input  logic                      valid,
	input  spc_pkg::spc_cell_ctl_t    ctl,
	input  logic [spc_pkg::KEY_W-1:0] req_key,
	input  logic [LOW_BITS-1:0]       req_low,
	input  logic                      left_lt,
	input  logic [spc_pkg::KEY_W-1:0] left_key,
	input  logic [LOW_BITS-1:0]       left_low,
	input  logic [spc_pkg::KEY_W-1:0] right_key,
	input  logic [LOW_BITS-1:0]       right_low,
	output logic [spc_pkg::KEY_W-1:0] key,
	output logic [LOW_BITS-1:0]       low,
	output spc_pkg::spc_flags_t       flags
);
	import spc_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [LOW_BITS-1:0] low_q;
	spc_flags_t flags_q;
	spc_flags_t flags_d;
	logic key_lt;
	logic key_eq;
	logic at_pos;

	// compare stored pair against the broadcast request
	always_comb begin
		key_lt = key_q < req_key;
		key_eq = key_q == req_key;
		flags_d.lt_pair = valid & (key_lt | (key_eq & (low_q < req_low)));
		flags_d.lt_key = valid & key_lt;
		flags_d.le_key = valid & (key_lt | key_eq);
		flags_d.eq_pair = valid & key_eq & (low_q == req_low);
	end

	// this cell is the insert point: left neighbor below, this one not
	assign at_pos = left_lt & ~flags_q.lt_pair;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			flags_q <= flags_d;
		end
	end

	// shift right on insert, left on remove, from the insert point on
	always_ff @(posedge clk) begin
		if (ctl.ins && at_pos) begin
			key_q <= req_key;
			low_q <= req_low;
		end else if (ctl.ins && !flags_q.lt_pair) begin
			key_q <= left_key;
			low_q <= left_low;
		end else if (ctl.rem && !flags_q.lt_pair) begin
			key_q <= right_key;
			low_q <= right_low;
		end
	end

	assign key = key_q;
	assign low = low_q;
	assign flags = flags_q;

endmodule

// ===== sv/spc_therm_enc.sv =====
module spc_therm_enc #(
	parameter int unsigned N = 64,
	parameter int unsigned CW = 7
) (
	input  logic [N-1:0]  therm,
	output logic [CW-1:0] count
);
	logic [N-1:0] prev;
	logic [N-1:0] edge_v;

	// lowest cells are set, so the first clear bit gives the count
	assign prev = {therm[N-2:0], 1'b1};
	assign edge_v = prev & ~therm;

	always_comb begin
		count = therm[N-1] ? CW'(N) : '0;
		for (int i = 0; i < N; i++) begin
			if (edge_v[i]) begin
				count = count | CW'(i);
			end
		end
	end

endmodule

// ===== sv/sorted_pair_set.sv =====
// channel  | handshake               | payload
// request  | req_valid / req_ready   | req (spc_request_t)
// result   | rsp_valid / rsp_ready   | rsp (spc_result_t)
//
// from a request transfer to its offered result, the steps are: compare in every cell,
// encode the cell flags, shift the cell row by one place, then form the header and result.
// one request is worked on at a time; a new transfer is taken in idle, in the cycle after
// the result step, even while a result waits.
// reset clears the pair count and the header key; cell contents stay unset.
// a result that is not taken holds the sequencer in its last step.
module sorted_pair_set #(
	parameter int unsigned MAX_PAIRS = 64,
	parameter int unsigned LOW_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  spc_pkg::spc_request_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output spc_pkg::spc_result_t rsp
);
	import spc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);

	spc_state_t state_q;
	spc_state_t state_d;
	spc_request_t req_q;
	logic [LOW_BITS-1:0] req_low;
	logic [CNT_W-1:0] count_q;
	logic [KEY_W-1:0] header_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] lb_q;
	logic [CNT_W-1:0] ub_q;
	logic hit_q;
	logic [STAT_W-1:0] status_q;
	logic found_q;
	logic [CNT_W-1:0] first_q;
	logic [CNT_W-1:0] match_q;
	logic changed_q;
	logic rsp_valid_q;
	spc_result_t rsp_q;

	spc_cell_ctl_t cell_ctl;
	logic do_ins;
	logic do_rem;
	logic [STAT_W-1:0] status_d;
	logic found_d;
	logic [CNT_W-1:0] first_d;
	logic [CNT_W-1:0] match_d;
	logic [CNT_W-1:0] count_d;
	logic [KEY_W-1:0] header_d;
	logic rsp_free;
	logic req_take;

	logic [KEY_W-1:0] key_w [MAX_PAIRS];
	logic [LOW_BITS-1:0] low_w [MAX_PAIRS];
	spc_flags_t flags_w [MAX_PAIRS];
	logic [MAX_PAIRS-1:0] lt_pair_v;
	logic [MAX_PAIRS-1:0] lt_key_v;
	logic [MAX_PAIRS-1:0] le_key_v;
	logic [MAX_PAIRS-1:0] eq_v;
	logic [CNT_W-1:0] pos_w;
	logic [CNT_W-1:0] lb_w;
	logic [CNT_W-1:0] ub_w;

	assign req_low = req_q.low_value[LOW_BITS-1:0];
	assign rsp_free = ~rsp_valid_q | rsp_ready;
	assign req_take = req_valid & req_ready;

	// row of cells, each handing its pair to a neighbor on a shift
	for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
		logic cell_valid;
		logic left_lt;
		logic [KEY_W-1:0] left_key;
		logic [LOW_BITS-1:0] left_low;
		logic [KEY_W-1:0] right_key;
		logic [LOW_BITS-1:0] right_low;

		assign cell_valid = count_q > CNT_W'(i);
		if (i == 0) begin : g_first
			assign left_lt = 1'b1;
			assign left_key = req_q.key;
			assign left_low = req_low;
		end else begin : g_mid
			assign left_lt = flags_w[i-1].lt_pair;
			assign left_key = key_w[i-1];
			assign left_low = low_w[i-1];
		end
		if (i == MAX_PAIRS - 1) begin : g_last
			assign right_key = key_w[i];
			assign right_low = low_w[i];
		end else begin : g_inner
			assign right_key = key_w[i+1];
			assign right_low = low_w[i+1];
		end

		spc_cell #(
			.LOW_BITS(LOW_BITS)
		) u_cell (
			.clk      (clk),
			.valid    (cell_valid),
			.ctl      (cell_ctl),
			.req_key  (req_q.key),
			.req_low  (req_low),
			.left_lt  (left_lt),
			.left_key (left_key),
			.left_low (left_low),
			.right_key(right_key),
			.right_low(right_low),
			.key      (key_w[i]),
			.low      (low_w[i]),
			.flags    (flags_w[i])
		);

		assign lt_pair_v[i] = flags_w[i].lt_pair;
		assign lt_key_v[i] = flags_w[i].lt_key;
		assign le_key_v[i] = flags_w[i].le_key;
		assign eq_v[i] = flags_w[i].eq_pair;
	end

	// positions from the flag rows
	spc_therm_enc #(.N(MAX_PAIRS), .CW(CNT_W)) u_enc_pos (.therm(lt_pair_v), .count(pos_w));
	spc_therm_enc #(.N(MAX_PAIRS), .CW(CNT_W)) u_enc_lb (.therm(lt_key_v), .count(lb_w));
	spc_therm_enc #(.N(MAX_PAIRS), .CW(CNT_W)) u_enc_ub (.therm(le_key_v), .count(ub_w));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: state_d = S_RESOLVE;
			S_RESOLVE: state_d = S_APPLY;
			S_APPLY: state_d = S_FINISH;
			S_FINISH: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		cell_ctl = '0;
		unique case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_CMP: cell_ctl.cmp = 1'b1;
			S_APPLY: begin
				cell_ctl.ins = do_ins;
				cell_ctl.rem = do_rem;
			end
			default: begin
			end
		endcase
	end

	// request decision from the encoded positions
	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		status_d = ST_DONE;
		found_d = 1'b0;
		first_d = pos_q;
		match_d = '0;
		count_d = count_q;
		unique case (req_q.action)
			ACT_CLEAR: begin
				first_d = '0;
				count_d = '0;
			end
			ACT_INSERT: begin
				if (hit_q) begin
					status_d = ST_DUPLICATE;
				end else if (count_q >= CNT_W'(MAX_PAIRS)) begin
					status_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (!hit_q) begin
					status_d = ST_NOT_FOUND;
				end else begin
					do_rem = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			ACT_CONTAINS: found_d = hit_q;
			ACT_FIND: begin
				first_d = lb_q;
				match_d = ub_q - lb_q;
			end
			default: first_d = '0;
		endcase
	end

	// header after the request
	always_comb begin
		if (req_q.action == ACT_CLEAR) begin
			header_d = req_q.key;
		end else if (changed_q) begin
			header_d = (count_q != '0) ? key_w[0] : '0;
		end else begin
			header_d = header_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			header_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_APPLY) begin
				count_q <= count_d;
			end
			if (state_q == S_FINISH && rsp_free) begin
				header_q <= header_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request, encoded positions, decision and result payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_q <= req;
		end
		if (state_q == S_RESOLVE) begin
			pos_q <= pos_w;
			lb_q <= lb_w;
			ub_q <= ub_w;
			hit_q <= |eq_v;
		end
		if (state_q == S_APPLY) begin
			status_q <= status_d;
			found_q <= found_d;
			first_q <= first_d;
			match_q <= match_d;
			changed_q <= do_ins | do_rem;
		end
		if (state_q == S_FINISH && rsp_free) begin
			rsp_q.status <= status_q;
			rsp_q.found <= found_q;
			rsp_q.first_index <= IDX_W'(first_q);
			rsp_q.match_count <= IDX_W'(match_q);
			rsp_q.pair_count <= IDX_W'(count_q);
			rsp_q.header_key <= header_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PAIRS))
		else $error("pair count above capacity");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && hit_q) |-> (pos_q < count_q))
		else $error("match found outside stored pairs");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> (ub_q >= lb_q && lb_q <= count_q && ub_q <= count_q))
		else $error("key range bounds out of order");

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == S_CMP))
		else $error("accepted request did not start compare");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_FINISH))
		else $error("result raised outside final step");
`endif

endmodule

// ===== tb/sv/tb_sorted_pair_set.sv =====
`timescale 1ns / 1ps

module tb_sorted_pair_set;
	import spc_pkg::*;

	localparam int unsigned SET_DEPTH = 64;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam logic [ACT_W-1:0] ACT_LAST = '1;
	localparam logic [KEY_W-1:0] KEY_TOP = '1;
	localparam logic [LOWV_W-1:0] LOW_TOP = '1;

	typedef struct packed {
		spc_request_t r;
		logic drain;
	} pending_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	spc_request_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	spc_result_t rsp;

	pending_req_t req_list[$];
	spc_result_t expect_q[$];
	logic req_fired = 1'b0;
	int sent = 0;
	int total_items = 0;
	int results_seen = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	int hold_next = 0;
	int hold_marks[2] = '{200, 1300};

	// shadow copy of the pair set
	logic [KEY_W-1:0] set_keys[SET_DEPTH];
	logic [LOWV_W-1:0] set_lows[SET_DEPTH];
	int set_count = 0;
	logic [KEY_W-1:0] set_header = '0;

	sorted_pair_set u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// apply one request to the shadow set and form its result
	function automatic spc_result_t set_apply(spc_request_t r);
		spc_result_t res;
		logic [LOWV_W-1:0] lk;
		int pos;
		int n;
		logic hit;
		res = '0;
		res.status = ST_DONE;
		lk = (r.action == ACT_FIND) ? '0 : r.low_value;
		pos = 0;
		// lower bound of (key, low)
		while (pos < set_count && (set_keys[pos] < r.key ||
				(set_keys[pos] == r.key && set_lows[pos] < lk)))
			pos++;
		hit = (pos < set_count) && set_keys[pos] == r.key && set_lows[pos] == lk;
		case (r.action)
			ACT_CLEAR: begin
				set_count = 0;
				set_header = r.key;
			end
			ACT_INSERT: begin
				res.first_index = IDX_W'(pos);
				if (hit) begin
					res.status = ST_DUPLICATE;
				end else if (set_count >= SET_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (n = set_count; n > pos; n--) begin
						set_keys[n] = set_keys[n-1];
						set_lows[n] = set_lows[n-1];
					end
					set_keys[pos] = r.key;
					set_lows[pos] = r.low_value;
					set_count++;
					set_header = set_keys[0];
				end
			end
			ACT_REMOVE: begin
				res.first_index = IDX_W'(pos);
				if (!hit) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (n = pos; n + 1 < set_count; n++) begin
						set_keys[n] = set_keys[n+1];
						set_lows[n] = set_lows[n+1];
					end
					set_count--;
					set_header = (set_count > 0) ? set_keys[0] : '0;
				end
			end
			ACT_CONTAINS: begin
				res.first_index = IDX_W'(pos);
				res.found = hit;
			end
			ACT_FIND: begin
				res.first_index = IDX_W'(pos);
				n = pos;
				while (n < set_count && set_keys[n] == r.key)
					n++;
				res.match_count = IDX_W'(n - pos);
			end
			default: begin
			end
		endcase
		res.pair_count = IDX_W'(set_count);
		res.header_key = set_header;
		return res;
	endfunction

	task automatic queue_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
			input logic [LOWV_W-1:0] lo, input logic drain);
		pending_req_t p;
		p.r.action = act;
		p.r.key = k;
		p.r.low_value = lo;
		p.drain = drain;
		req_list.push_back(p);
	endtask

	task automatic check_field(input string name, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// idle percentages per phase: 0 = sender 6 / receiver 55, 1 = swapped, 2 = none
	function automatic int idle_phase();
		if (sent * 3 < total_items)
			return 0;
		else if (sent * 3 < 2 * total_items)
			return 1;
		return 2;
	endfunction

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		int pct;
		pct = (idle_phase() == 0) ? 6 : (idle_phase() == 1) ? 55 : 0;
		if (arst_n && (!req_valid || req_fired)) begin
			if (req_list.size() > 0 && !(req_list[0].drain && expect_q.size() > 0) &&
					$urandom_range(99) >= pct) begin
				req <= req_list[0].r;
				req_valid <= 1'b1;
				void'(req_list.pop_front());
				sent++;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result receiver, with long hold-offs to back up the request side
	always @(negedge clk) begin
		int pct;
		pct = (idle_phase() == 0) ? 55 : (idle_phase() == 1) ? 6 : 0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (hold_next < 2 && results_seen >= hold_marks[hold_next]) begin
				hold_left <= HOLD_CYCLES;
				hold_next <= hold_next + 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= pct);
			end
		end
	end

	// monitor: check each result transfer, predict each request transfer
	always @(posedge clk) begin
		spc_result_t want;
		if (!arst_n) begin
			req_fired <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (expect_q.size() == 0) begin
					$display("%0t: result transfer with none expected, actual %p", $time, rsp);
					errors++;
				end else begin
					want = expect_q.pop_front();
					check_field("status", KEY_W'(want.status), KEY_W'(rsp.status));
					check_field("found", KEY_W'(want.found), KEY_W'(rsp.found));
					check_field("first_index", KEY_W'(want.first_index),
						KEY_W'(rsp.first_index));
					check_field("match_count", KEY_W'(want.match_count),
						KEY_W'(rsp.match_count));
					check_field("pair_count", KEY_W'(want.pair_count), KEY_W'(rsp.pair_count));
					check_field("header_key", want.header_key, rsp.header_key);
				end
			end
			if (req_valid && req_ready)
				expect_q.push_back(set_apply(req));
			req_fired <= req_valid && req_ready;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [KEY_W-1:0] key_pool[16];
		logic [LOWV_W-1:0] low_pool[8];
		logic [KEY_W-1:0] base;
		int a;
		int i;
		int ops;
		int roll;
		int pool_n;
		bit fill;
		bit first_ep;

		// directed: empty set, extremes, duplicates, header moves, unknown codes
		queue_request(ACT_CONTAINS, '0, '0, 1'b0);
		queue_request(ACT_FIND, '0, '0, 1'b0);
		queue_request(ACT_REMOVE, KEY_TOP, LOW_TOP, 1'b0);
		queue_request(ACT_INSERT, KEY_TOP, LOW_TOP, 1'b0);
		queue_request(ACT_INSERT, '0, '0, 1'b0);
		queue_request(ACT_INSERT, '0, '0, 1'b0);
		queue_request(ACT_INSERT, '0, LOW_TOP, 1'b0);
		queue_request(ACT_INSERT, KEY_TOP, '0, 1'b0);
		queue_request(ACT_CONTAINS, '0, LOW_TOP, 1'b0);
		queue_request(ACT_CONTAINS, KEY_TOP, 16'h0001, 1'b0);
		queue_request(ACT_FIND, '0, LOW_TOP, 1'b0);
		queue_request(ACT_FIND, KEY_TOP, '0, 1'b0);
		queue_request(ACT_FIND, 32'h0000_0005, '0, 1'b0);
		queue_request(ACT_REMOVE, '0, '0, 1'b0);
		queue_request(ACT_REMOVE, '0, LOW_TOP, 1'b0);
		queue_request(ACT_REMOVE, 32'h0000_0007, 16'h0007, 1'b0);
		for (a = int'(ACT_FIND) + 1; a <= int'(ACT_LAST); a++)
			queue_request(ACT_W'(a), $urandom, 16'($urandom), 1'b0);
		queue_request(ACT_REMOVE, KEY_TOP, LOW_TOP, 1'b0);
		queue_request(ACT_REMOVE, KEY_TOP, '0, 1'b0);
		queue_request(ACT_CLEAR, 32'hA5A5_A5A5, LOW_TOP, 1'b0);
		queue_request(ACT_FIND, 32'hA5A5_A5A5, '0, 1'b0);
		queue_request(ACT_CLEAR, KEY_TOP, '0, 1'b0);
		queue_request(ACT_CLEAR, '0, '0, 1'b0);

		// random episodes: clear, then a burst over a small pool of pairs
		first_ep = 1'b1;
		while (req_list.size() < RANDOM_ITEMS - 40) begin
			fill = ($urandom_range(4) == 0);
			pool_n = fill ? 16 : 5;
			roll = $urandom_range(3);
			base = (roll == 0) ? '0 : (roll == 1) ? KEY_TOP - 15 : $urandom;
			for (i = 0; i < 16; i++)
				key_pool[i] = (roll == 3) ? $urandom : base + i;
			low_pool[0] = '0;
			low_pool[1] = LOW_TOP;
			for (i = 2; i < 8; i++)
				low_pool[i] = ($urandom_range(1) == 0) ? LOWV_W'(i) : 16'($urandom);
			queue_request(ACT_CLEAR, ($urandom_range(3) == 0) ? key_pool[0] : $urandom,
				16'($urandom), first_ep || ($urandom_range(3) == 0));
			first_ep = 1'b0;
			// fill bursts run long enough to reach a full set
			ops = fill ? $urandom_range(120, 160) : $urandom_range(10, 60);
			for (i = 0; i < ops; i++) begin
				roll = $urandom_range(99);
				if (roll < 5)
					queue_request(ACT_W'($urandom_range(int'(ACT_LAST))), $urandom,
						16'($urandom), 1'b0);
				else
					queue_request(
						(roll < (fill ? 80 : 50)) ? ACT_INSERT :
						(roll < (fill ? 88 : 70)) ? ACT_REMOVE :
						(roll < (fill ? 94 : 85)) ? ACT_CONTAINS : ACT_FIND,
						key_pool[$urandom_range(pool_n - 1)],
						low_pool[$urandom_range(7)], 1'b0);
			end
		end
		total_items = req_list.size();

		// reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_list.size() > 0 || req_valid || expect_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/spc_pkg.sv
sv/spc_cell.sv
sv/spc_therm_enc.sv
sv/sorted_pair_set.sv
tb/sv/tb_sorted_pair_set.sv
